>>> src/lbdb_pkg.sv
package lbdb_pkg;

    // Width of the tick countdown; delay loads saturate at its largest value.
    localparam int CountWidth = 16;
    localparam logic [32:0] CntMax = (33'd1 << CountWidth) - 33'd1;

    // Register indexes on the configuration port (byte address = 4 * index).
    localparam logic [2:0] RegLowThreshold   = 3'd0;
    localparam logic [2:0] RegOnTicks        = 3'd1;
    localparam logic [2:0] RegGapTicks       = 3'd2;
    localparam logic [2:0] RegRepeatTicks    = 3'd3;
    localparam logic [2:0] RegUsbRecheck     = 3'd4;
    localparam logic [2:0] RegInitialDelay   = 3'd5;

    // Register reset values.
    localparam logic [6:0]  ThresholdReset = 7'd15;
    localparam logic [15:0] OnReset        = 16'd180;
    localparam logic [15:0] GapReset       = 16'd220;
    localparam logic [15:0] RepeatReset    = 16'd60000;
    localparam logic [15:0] UsbReset       = 16'd10000;
    localparam logic [15:0] InitReset      = 16'd5000;

    // Level value that means no charge reading has been seen yet.
    localparam logic [7:0] LevelUnknown = 8'd255;

    // Blink phases.
    localparam logic [1:0] PhaseIdle   = 2'd0;
    localparam logic [1:0] PhaseFirst  = 2'd1;
    localparam logic [1:0] PhaseGap    = 2'd2;
    localparam logic [1:0] PhaseSecond = 2'd3;

    typedef struct packed {
        logic       charge_event;
        logic [6:0] charge;
        logic       usb_present;
    } t_in_beat;

    typedef struct packed {
        logic       led_on;
        logic [1:0] blink_phase;
        logic       battery_low;
    } t_out_beat;

    typedef struct packed {
        logic [6:0]  low_threshold;
        logic [15:0] on_ticks;
        logic [15:0] gap_ticks;
        logic [15:0] repeat_ticks;
        logic [15:0] usb_recheck_ticks;
        logic [15:0] initial_delay_ticks;
    } t_cfg;

    typedef struct packed {
        logic [7:0]            level;
        logic [1:0]            phase;
        logic                  pending;
        logic [CountWidth-1:0] countdown;
        logic                  led;
        logic                  awaiting;
    } t_state;

    // Saturating load of a 16-bit delay into the countdown.
    function automatic logic [CountWidth-1:0] clamp_count(input logic [15:0] d);
        logic [32:0] wide;
        wide = 33'(d);
        if (wide > CntMax) begin
            return CountWidth'(CntMax);
        end
        return CountWidth'(wide);
    endfunction

endpackage

>>> src/low_battery_double_blink.sv
// Channel   | Direction | Handshake                   | Payload
// input     | in        | i_in_valid / o_in_stall     | i_in_beat  (lbdb_pkg::t_in_beat)
// output    | out       | o_out_valid / i_out_stall   | o_out_beat (lbdb_pkg::t_out_beat)
// config    | in        | psel, penable, pwrite/pready | paddr, pwdata, prdata
//
// One tick beat is accepted every cycle while o_in_stall is low; its result is set
// by the single next-state step between the state and output registers.
// Reset is synchronous and active low; it restores the registers, arms the
// initial delay and empties the output buffer.
// A two-entry output buffer lets one beat enter while a result is held;
// o_in_stall rises only once both entries are full.
module low_battery_double_blink (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  lbdb_pkg::t_in_beat   i_in_beat,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output lbdb_pkg::t_out_beat  o_out_beat,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    lbdb_pkg::t_cfg      w_cfg;
    logic                w_init_wr;
    lbdb_pkg::t_state    r_state;
    lbdb_pkg::t_state    n_state;
    lbdb_pkg::t_out_beat w_res;
    lbdb_pkg::t_out_beat r_out;
    lbdb_pkg::t_out_beat r_skid;
    logic                r_out_valid;
    logic                r_skid_valid;
    logic                w_accept;
    logic                w_take;

    lbdb_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_cfg     (w_cfg),
        .o_init_wr (w_init_wr)
    );

    lbdb_step u_step (
        .i_cfg   (w_cfg),
        .i_state (r_state),
        .i_beat  (i_in_beat),
        .o_state (n_state),
        .o_beat  (w_res)
    );

    assign w_accept = i_in_valid & ~r_skid_valid;
    assign w_take   = r_out_valid & ~i_out_stall;

    // Indicator state; a write of the initial delay during the first wait reloads it unless a beat is accepted.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.level     <= lbdb_pkg::LevelUnknown;
            r_state.phase     <= lbdb_pkg::PhaseIdle;
            r_state.pending   <= 1'b1;
            r_state.countdown <= lbdb_pkg::clamp_count(lbdb_pkg::InitReset);
            r_state.led       <= 1'b0;
            r_state.awaiting  <= 1'b1;
        end else if (w_accept) begin
            r_state <= n_state;
        end else if (w_init_wr && r_state.awaiting) begin
            r_state.countdown <= lbdb_pkg::clamp_count(pwdata[15:0]);
        end
    end

    // Output register with a skid entry behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_take || !r_out_valid) begin
            r_out_valid  <= r_skid_valid | w_accept;
            r_skid_valid <= 1'b0;
        end else if (w_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take || !r_out_valid) begin
            r_out <= r_skid_valid ? r_skid : w_res;
        end else if (w_accept) begin
            r_skid <= w_res;
        end
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

endmodule

>>> src/lbdb_regs.sv
module lbdb_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output lbdb_pkg::t_cfg      o_cfg,
    output logic                o_init_wr
);

    lbdb_pkg::t_cfg r_cfg;
    logic           w_wr;
    logic [2:0]     w_idx;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];
    assign w_wr   = psel & penable & pwrite;

    // Register file; writes beyond the last register are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_threshold       <= lbdb_pkg::ThresholdReset;
            r_cfg.on_ticks            <= lbdb_pkg::OnReset;
            r_cfg.gap_ticks           <= lbdb_pkg::GapReset;
            r_cfg.repeat_ticks        <= lbdb_pkg::RepeatReset;
            r_cfg.usb_recheck_ticks   <= lbdb_pkg::UsbReset;
            r_cfg.initial_delay_ticks <= lbdb_pkg::InitReset;
        end else if (w_wr) begin
            unique case (w_idx)
                lbdb_pkg::RegLowThreshold: r_cfg.low_threshold       <= pwdata[6:0];
                lbdb_pkg::RegOnTicks:      r_cfg.on_ticks            <= pwdata[15:0];
                lbdb_pkg::RegGapTicks:     r_cfg.gap_ticks           <= pwdata[15:0];
                lbdb_pkg::RegRepeatTicks:  r_cfg.repeat_ticks        <= pwdata[15:0];
                lbdb_pkg::RegUsbRecheck:   r_cfg.usb_recheck_ticks   <= pwdata[15:0];
                lbdb_pkg::RegInitialDelay: r_cfg.initial_delay_ticks <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read-back mux.
    always_comb begin
        unique case (w_idx)
            lbdb_pkg::RegLowThreshold: prdata = 32'(r_cfg.low_threshold);
            lbdb_pkg::RegOnTicks:      prdata = 32'(r_cfg.on_ticks);
            lbdb_pkg::RegGapTicks:     prdata = 32'(r_cfg.gap_ticks);
            lbdb_pkg::RegRepeatTicks:  prdata = 32'(r_cfg.repeat_ticks);
            lbdb_pkg::RegUsbRecheck:   prdata = 32'(r_cfg.usb_recheck_ticks);
            lbdb_pkg::RegInitialDelay: prdata = 32'(r_cfg.initial_delay_ticks);
            default:                   prdata = 32'd0;
        endcase
    end

    assign o_cfg     = r_cfg;
    assign o_init_wr = w_wr && (w_idx == lbdb_pkg::RegInitialDelay);

endmodule

>>> src/lbdb_step.sv
module lbdb_step (
    input  lbdb_pkg::t_cfg     i_cfg,
    input  lbdb_pkg::t_state   i_state,
    input  lbdb_pkg::t_in_beat i_beat,
    output lbdb_pkg::t_state   o_state,
    output lbdb_pkg::t_out_beat o_beat
);

    lbdb_pkg::t_state s;
    logic [7:0]       w_thr;
    logic [7:0]       w_charge;

    assign w_thr    = 8'(i_cfg.low_threshold);
    assign w_charge = 8'(i_beat.charge);

    // One timer tick: the charge event first, then the countdown and firing.
    always_comb begin
        s = i_state;

        if (i_beat.charge_event) begin
            s.level = w_charge;
            if (s.level <= w_thr) begin
                if (!s.pending) begin
                    s.pending   = 1'b1;
                    s.countdown = '0;
                    s.awaiting  = 1'b0;
                end
            end else begin
                s.pending  = 1'b0;
                s.phase    = lbdb_pkg::PhaseIdle;
                s.led      = 1'b0;
                s.awaiting = 1'b0;
            end
        end

        if (s.pending) begin
            if (s.countdown != '0) begin
                s.countdown = s.countdown - lbdb_pkg::CountWidth'(1);
            end
            if (s.countdown == '0) begin
                // Timer fires.
                s.awaiting = 1'b0;
                s.pending  = 1'b0;
                if (s.level == lbdb_pkg::LevelUnknown) begin
                    s.level = w_charge;
                end
                if (s.level > w_thr) begin
                    s.phase = lbdb_pkg::PhaseIdle;
                    s.led   = 1'b0;
                end else if (i_beat.usb_present) begin
                    s.phase     = lbdb_pkg::PhaseIdle;
                    s.led       = 1'b0;
                    s.pending   = 1'b1;
                    s.countdown = lbdb_pkg::clamp_count(i_cfg.usb_recheck_ticks);
                end else begin
                    s.pending = 1'b1;
                    case (s.phase)
                        lbdb_pkg::PhaseIdle: begin
                            s.led       = 1'b1;
                            s.phase     = lbdb_pkg::PhaseFirst;
                            s.countdown = lbdb_pkg::clamp_count(i_cfg.on_ticks);
                        end
                        lbdb_pkg::PhaseFirst: begin
                            s.led       = 1'b0;
                            s.phase     = lbdb_pkg::PhaseGap;
                            s.countdown = lbdb_pkg::clamp_count(i_cfg.gap_ticks);
                        end
                        lbdb_pkg::PhaseGap: begin
                            s.led       = 1'b1;
                            s.phase     = lbdb_pkg::PhaseSecond;
                            s.countdown = lbdb_pkg::clamp_count(i_cfg.on_ticks);
                        end
                        default: begin
                            s.led       = 1'b0;
                            s.phase     = lbdb_pkg::PhaseIdle;
                            s.countdown = lbdb_pkg::clamp_count(i_cfg.repeat_ticks);
                        end
                    endcase
                end
            end
        end
    end

    assign o_state            = s;
    assign o_beat.led_on      = s.led;
    assign o_beat.blink_phase = s.phase;
    assign o_beat.battery_low = (s.level <= w_thr);

endmodule

>>> src/lbdb_checker.sv
module lbdb_port_checks (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input lbdb_pkg::t_out_beat o_out_beat
);

    // A held result stays put until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_beat))
        else $error("held output beat changed or vanished");

    // The input side only stalls while a result is waiting in front of it.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with an empty output register");

    // The LED is lit exactly in the two on phases.
    a_led_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_beat.led_on == o_out_beat.blink_phase[0]))
        else $error("LED state disagrees with blink phase");

    // Nothing is offered in the first cycle out of reset.
    a_reset_empty: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_out_valid && !o_in_stall)
        else $error("output buffer not empty after reset");

endmodule

bind low_battery_double_blink lbdb_port_checks u_lbdb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_beat  (o_out_beat)
);

>>> tb/lbdb_checker.sv
`timescale 1ns / 1ps

// Watches the tick, indicator and register channels of the low-battery
// indicator, keeps its own copy of the indicator state and checks every
// indicator beat against the oldest predicted one.
module lbdb_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  lbdb_pkg::t_in_beat  i_in_beat,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  lbdb_pkg::t_out_beat i_out_beat,
    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic                i_pready,
    input  logic [4:0]          i_paddr,
    input  logic [31:0]         i_pwdata,
    output int                  o_err_count,
    output int                  o_pending,
    output int                  o_checked
);

    // Shadow copy of the register file.
    logic [6:0]  thr_reg;
    logic [15:0] on_reg;
    logic [15:0] gap_reg;
    logic [15:0] repeat_reg;
    logic [15:0] usb_reg;
    logic [15:0] init_reg;

    // Shadow copy of the indicator state.
    logic [7:0]                      level;
    logic [1:0]                      phase;
    logic                            armed;
    logic [lbdb_pkg::CountWidth-1:0] ticks_left;
    logic                            led;
    logic                            first_wait;

    // Indicator beats predicted but not yet seen on the output channel.
    lbdb_pkg::t_out_beat indicator_q[$];

    function automatic logic level_is_low();
        return level <= {1'b0, thr_reg};
    endfunction

    // The countdown is as wide as the delay registers, so a load never saturates.
    task automatic arm_timer(input logic [15:0] delay);
        armed      = 1'b1;
        ticks_left = delay;
    endtask

    task automatic restore_defaults();
        thr_reg    = lbdb_pkg::ThresholdReset;
        on_reg     = lbdb_pkg::OnReset;
        gap_reg    = lbdb_pkg::GapReset;
        repeat_reg = lbdb_pkg::RepeatReset;
        usb_reg    = lbdb_pkg::UsbReset;
        init_reg   = lbdb_pkg::InitReset;
        level      = lbdb_pkg::LevelUnknown;
        phase      = lbdb_pkg::PhaseIdle;
        led        = 1'b0;
        arm_timer(init_reg);
        first_wait = 1'b1;
    endtask

    task automatic apply_write(input logic [2:0] idx, input logic [31:0] value);
        case (idx)
            lbdb_pkg::RegLowThreshold: thr_reg = value[6:0];
            lbdb_pkg::RegOnTicks:      on_reg = value[15:0];
            lbdb_pkg::RegGapTicks:     gap_reg = value[15:0];
            lbdb_pkg::RegRepeatTicks:  repeat_reg = value[15:0];
            lbdb_pkg::RegUsbRecheck:   usb_reg = value[15:0];
            lbdb_pkg::RegInitialDelay: begin
                init_reg = value[15:0];
                // Only the untouched initial wait picks up a new initial delay.
                if (first_wait) begin
                    ticks_left = value[15:0];
                end
            end
            default: ;
        endcase
    endtask

    // One expiry of the timer: take the next step of the double blink.
    task automatic timer_expired(input logic [6:0] charge, input logic usb);
        armed = 1'b0;
        if (level == lbdb_pkg::LevelUnknown) begin
            level = {1'b0, charge};
        end
        if (!level_is_low()) begin
            phase = lbdb_pkg::PhaseIdle;
            led   = 1'b0;
        end else if (usb) begin
            phase = lbdb_pkg::PhaseIdle;
            led   = 1'b0;
            arm_timer(usb_reg);
        end else begin
            case (phase)
                lbdb_pkg::PhaseIdle: begin
                    led   = 1'b1;
                    phase = lbdb_pkg::PhaseFirst;
                    arm_timer(on_reg);
                end
                lbdb_pkg::PhaseFirst: begin
                    led   = 1'b0;
                    phase = lbdb_pkg::PhaseGap;
                    arm_timer(gap_reg);
                end
                lbdb_pkg::PhaseGap: begin
                    led   = 1'b1;
                    phase = lbdb_pkg::PhaseSecond;
                    arm_timer(on_reg);
                end
                default: begin
                    led   = 1'b0;
                    phase = lbdb_pkg::PhaseIdle;
                    arm_timer(repeat_reg);
                end
            endcase
        end
    endtask

    // One tick: the charge event is taken first, then the timer is served.
    task automatic advance_tick(input lbdb_pkg::t_in_beat beat,
                                output lbdb_pkg::t_out_beat res);
        if (beat.charge_event) begin
            level = {1'b0, beat.charge};
            if (level_is_low()) begin
                if (!armed) begin
                    arm_timer(16'd0);
                    first_wait = 1'b0;
                end
            end else begin
                armed      = 1'b0;
                phase      = lbdb_pkg::PhaseIdle;
                led        = 1'b0;
                first_wait = 1'b0;
            end
        end
        if (armed) begin
            if (ticks_left != 0) begin
                ticks_left = ticks_left - lbdb_pkg::CountWidth'(1);
            end
            if (ticks_left == 0) begin
                first_wait = 1'b0;
                timer_expired(beat.charge, beat.usb_present);
            end
        end
        res.led_on      = led;
        res.blink_phase = phase;
        res.battery_low = level_is_low();
    endtask

    // Register writes and tick beats update the prediction; indicator beats are compared.
    always @(posedge i_clk) begin : watch
        lbdb_pkg::t_out_beat want;
        if (!i_rst_n) begin
            restore_defaults();
            indicator_q.delete();
            o_err_count = 0;
            o_checked   = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                apply_write(i_paddr[4:2], i_pwdata);
            end
            if (i_in_valid && !i_in_stall) begin
                advance_tick(i_in_beat, want);
                indicator_q.push_back(want);
            end
            if (i_out_valid && !i_out_stall) begin
                if (indicator_q.size() == 0) begin
                    $error("indicator beat with no prediction waiting: %b", i_out_beat);
                    o_err_count = o_err_count + 1;
                end else begin
                    want = indicator_q.pop_front();
                    o_checked = o_checked + 1;
                    if (i_out_beat.led_on !== want.led_on) begin
                        $error("led_on: expected %0b, actual %0b",
                               want.led_on, i_out_beat.led_on);
                        o_err_count = o_err_count + 1;
                    end
                    if (i_out_beat.blink_phase !== want.blink_phase) begin
                        $error("blink_phase: expected %0d, actual %0d",
                               want.blink_phase, i_out_beat.blink_phase);
                        o_err_count = o_err_count + 1;
                    end
                    if (i_out_beat.battery_low !== want.battery_low) begin
                        $error("battery_low: expected %0b, actual %0b",
                               want.battery_low, i_out_beat.battery_low);
                        o_err_count = o_err_count + 1;
                    end
                end
            end
        end
        o_pending = indicator_q.size();
    end

endmodule

>>> tb/tb_low_battery_double_blink.sv
`timescale 1ns / 1ps

module tb_low_battery_double_blink;

    localparam int CycleLimit = 200000;
    localparam int HoldCycles = 60;

    // Register indexes past the end of the register file.
    localparam logic [2:0] RegSpareLo = 3'd6;
    localparam logic [2:0] RegSpareHi = 3'd7;

    typedef enum int {RxFree, RxLight, RxHeavy, RxPeriodic} t_rx_mode;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    lbdb_pkg::t_in_beat in_beat   = '0;
    logic               out_stall = 1'b0;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [4:0]         paddr     = '0;
    logic [31:0]        pwdata    = '0;

    logic                in_stall;
    logic                out_valid;
    lbdb_pkg::t_out_beat out_beat;
    logic [31:0]         prdata;
    logic                pready;

    int err_count;
    int pending;
    int checked;

    int         sent     = 0;
    int         settings = 0;
    logic [6:0] thr_now  = lbdb_pkg::ThresholdReset;
    logic       usb_now  = 1'b0;

    logic     hold_req  = 1'b0;
    logic     hold_ack  = 1'b0;
    int       hold_left = 0;
    int       rx_cycle  = 0;
    t_rx_mode rx_mode   = RxFree;
    int       cycles    = 0;

    always #6 clk = ~clk;

    low_battery_double_blink uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (out_beat),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    lbdb_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_beat   (in_beat),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_beat  (out_beat),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_pready    (pready),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .o_err_count (err_count),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    // Receiver: a long hold-off on request, otherwise a stall pattern that
    // changes its character at random among free, light, heavy and periodic.
    always @(negedge clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end else if (hold_req != hold_ack) begin
            hold_ack  = hold_req;
            hold_left = HoldCycles;
            out_stall <= 1'b1;
        end else begin
            if (rx_cycle % 48 == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
            end
            case (rx_mode)
                RxFree:   out_stall <= 1'b0;
                RxLight:  out_stall <= ($urandom_range(0, 7) == 0);
                RxHeavy:  out_stall <= $urandom_range(0, 1);
                default:  out_stall <= ((rx_cycle % 8) < 3);
            endcase
        end
        rx_cycle = rx_cycle + 1;
    end

    // Watchdog on the total run length.
    always @(posedge clk) begin
        cycles = cycles + 1;
        if (cycles > CycleLimit) begin
            $display("tb_low_battery_double_blink: done, errors");
            $finish;
        end
    end

    // Offers one tick beat from a falling edge and holds it until it is taken.
    task automatic send_tick(input logic ev, input logic [6:0] chg, input logic usb);
        lbdb_pkg::t_in_beat beat;
        beat.charge_event = ev;
        beat.charge       = chg;
        beat.usb_present  = usb;
        in_valid <= 1'b1;
        in_beat  <= beat;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        sent = sent + 1;
        @(negedge clk);
    endtask

    task automatic idle_for(input int n);
        in_valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // Stops offering beats until every predicted indicator beat has arrived.
    task automatic drain();
        idle_for(1);
        while (pending != 0) begin
            @(negedge clk);
        end
        repeat (3) @(negedge clk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) begin
            @(posedge clk);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Writes the whole register file; the unused upper data bits carry noise.
    task automatic program_regs(input logic [6:0] thr, input logic [15:0] on_t,
                                input logic [15:0] gap_t, input logic [15:0] rep_t,
                                input logic [15:0] usb_t, input logic [15:0] init_t);
        logic [31:0] junk;
        junk = $urandom;
        reg_write(lbdb_pkg::RegLowThreshold, {junk[31:7], thr});
        reg_write(lbdb_pkg::RegOnTicks,      {junk[31:16], on_t});
        reg_write(lbdb_pkg::RegGapTicks,     {junk[15:0], gap_t});
        reg_write(lbdb_pkg::RegRepeatTicks,  {junk[23:8], rep_t});
        reg_write(lbdb_pkg::RegUsbRecheck,   {junk[31:16], usb_t});
        reg_write(lbdb_pkg::RegInitialDelay, {junk[15:0], init_t});
        thr_now  = thr;
        settings = settings + 1;
    endtask

    // Mostly rare events with charges close to the threshold, so that blink
    // sequences run long; now and then any charge at all.
    task automatic random_tick();
        int  chg;
        logic ev;
        ev = ($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 3) == 0) begin
            chg = $urandom_range(0, 127);
        end else begin
            chg = int'(thr_now) + int'($urandom_range(0, 6)) - 3;
            if (chg < 0) begin
                chg = 0;
            end
            if (chg > 127) begin
                chg = 127;
            end
        end
        if ($urandom_range(0, 15) == 0) begin
            usb_now = ~usb_now;
        end
        send_tick(ev, chg[6:0], usb_now);
    endtask

    task automatic random_phase(input int n, input bit squeeze);
        int left;
        int burst;
        int gap;
        left = n;
        // Back-to-back beats against a long receiver hold-off fill the block.
        if (squeeze) begin
            hold_req <= ~hold_req;
            repeat (30) random_tick();
            left = left - 30;
            drain();
        end
        while (left > 0) begin
            burst = $urandom_range(1, 20);
            if (burst > left) begin
                burst = left;
            end
            repeat (burst) random_tick();
            left = left - burst;
            case ($urandom_range(0, 5))
                0, 1:    gap = 0;
                5:       gap = $urandom_range(8, 20);
                default: gap = $urandom_range(1, 4);
            endcase
            if (gap > 0) begin
                idle_for(gap);
            end
        end
        drain();
    endtask

    initial begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        idle_for(2);

        // A few ticks of the initial wait with the reset register values.
        repeat (3) send_tick(1'b0, 7'd50, 1'b0);
        drain();

        // Shortening the initial delay while it still runs reloads the countdown.
        reg_write(lbdb_pkg::RegInitialDelay, 32'd3);
        reg_write(lbdb_pkg::RegOnTicks, 32'd2);
        reg_write(lbdb_pkg::RegGapTicks, 32'd3);
        reg_write(lbdb_pkg::RegRepeatTicks, 32'd4);
        reg_write(lbdb_pkg::RegUsbRecheck, 32'd2);
        settings = settings + 1;

        // First expiry with the level still unknown takes the tick's charge,
        // then a full double blink and the start of the repeat wait.
        repeat (10) send_tick(1'b0, 7'd5, 1'b0);
        // High level cancels; a low event with nothing pending fires at once.
        send_tick(1'b1, 7'd100, 1'b0);
        send_tick(1'b1, 7'd0, 1'b0);
        // Low event while the timer runs leaves it alone; expiry sees USB power.
        send_tick(1'b1, 7'd3, 1'b0);
        send_tick(1'b0, 7'd3, 1'b1);
        send_tick(1'b1, 7'd127, 1'b1);
        // Exactly at the threshold counts as low.
        send_tick(1'b1, 7'd15, 1'b1);
        send_tick(1'b0, 7'd15, 1'b0);
        send_tick(1'b0, 7'd15, 1'b0);
        send_tick(1'b1, 7'd16, 1'b0);
        drain();

        // Writes past the register file must change nothing.
        reg_write(RegSpareLo, 32'hFFFF_FFFF);
        reg_write(RegSpareHi, 32'h0000_0001);

        program_regs(7'd15, 16'd1, 16'd1, 16'd2, 16'd1, 16'd7);
        random_phase(75, 1'b0);
        program_regs(7'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        random_phase(75, 1'b0);
        program_regs(7'd127, 16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
                     16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
                     16'($urandom_range(1, 6)));
        random_phase(75, 1'b0);
        program_regs(7'd100, 16'd3, 16'd65535, 16'd1, 16'd65535, 16'd65535);
        random_phase(75, 1'b0);
        program_regs(7'($urandom_range(0, 127)), 16'($urandom_range(0, 8)),
                     16'($urandom_range(0, 8)), 16'($urandom_range(0, 8)),
                     16'($urandom_range(0, 8)), 16'($urandom_range(0, 8)));
        random_phase(75, 1'b1);
        program_regs(7'd40, 16'd2, 16'd5, 16'd10, 16'd3, 16'd1);
        random_phase(75, 1'b0);

        // Let the last beats settle before the verdict.
        idle_for(1);
        while (pending != 0) begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);

        $display("Run covered %0d tick beats under %0d register settings, including",
                 sent, settings);
        $display("zero, unit and full-scale delays, threshold extremes and a receiver hold-off;");
        $display("%0d indicator beats were compared.", checked);
        if (err_count == 0 && pending == 0) begin
            $display("tb_low_battery_double_blink: done, clean");
        end else begin
            $display("tb_low_battery_double_blink: done, errors");
        end
        $finish;
    end

endmodule
